@@ hw/rtl/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg - shared types and constants for the trial-division prime test
// Default value width and the status bundles passed between the sequencer,
// the remainder unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    // default width of the value under test
    localparam int VALUE_BITS_DEF = 16;

    // first trial divisor and its square
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = 4;

    // remainder unit -> sequencer
    typedef struct packed {
        logic done;     // one-cycle pulse, remainder ready
        logic zero;     // remainder is zero, valid with done
    } rem_sts_t;

    // sequencer -> top level
    typedef struct packed {
        logic in_ready;   // idle, can take a value
        logic out_load;   // load the verdict into the output register
        logic out_prime;  // verdict, valid with out_load
    } ctrl_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/trial_division_prime_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test - primality test by trial division
// Takes one unsigned value per beat on the s_axis side and returns one beat
// on the m_axis side: bit 0 of m_axis_tdata is 1 when the value is prime.
//
// Usage notes:
//  - Input: s_axis_tdata[VALUE_BITS-1:0] is the value; upper pad bits ignored.
//  - Output: m_axis_tdata[0] is is_prime, other bits zero.
//  - 0 and 1 give not prime; otherwise divisors d = 2, 3, ... are tried while
//    d*d <= value, stopping at the first zero remainder.
//  - Each divisor costs one square check in the sequencer plus a pass through
//    the shared bit-serial remainder unit.
//    Worst case for 16 bits is a large prime: 254 divisors.
//    Values 0 to 3 need no division, even values only the one by 2.
//  - One value at a time: s_axis_tready is high only while the sequencer is
//    idle. The verdict sits in an output register, so the next value is
//    accepted while a result still waits on m_axis_tready.
//  - If the receiver stalls with a result already waiting, the next verdict
//    is held in the sequencer until the output register frees up.
//  - Reset (aresetn low, synchronous) drops any work in flight and clears
//    the output valid; the block comes up ready.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input value beat
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // [VALUE_BITS-1:0] value
    // result beat
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [7:0]                                m_axis_tdata   // [0] is_prime
);

    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

    tdpt_pkg::rem_sts_t    rem_sts;
    tdpt_pkg::ctrl_sts_t   ctrl_sts;
    logic                  rem_start;
    logic [VALUE_BITS-1:0] rem_dividend;
    logic [DIV_BITS-1:0]   rem_divisor;
    logic                  out_valid_reg;
    logic                  out_prime_reg;
    logic                  out_free;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    tdpt_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_value     (s_axis_tdata[VALUE_BITS-1:0]),
        .out_free     (out_free),
        .rem_sts      (rem_sts),
        .rem_start    (rem_start),
        .rem_dividend (rem_dividend),
        .rem_divisor  (rem_divisor),
        .sts          (ctrl_sts)
    );

    tdpt_rem_unit #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .sts      (rem_sts)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_prime_reg <= 1'b0;
        end else if (ctrl_sts.out_load) begin
            out_valid_reg <= 1'b1;
            out_prime_reg <= ctrl_sts.out_prime;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign s_axis_tready = ctrl_sts.in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_prime_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // one value at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("took a new beat while still busy");

    // verdict never overwrites an undelivered result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_sts.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten");

    // remainder unit only reports while a value is under test
    a_rem_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_sts.done |-> !ctrl_sts.in_ready)
        else $error("remainder done while idle");

    // remainder start never fires back to back
    a_start_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_start |=> !rem_start)
        else $error("back-to-back remainder start");

endmodule

`default_nettype wire

@@ hw/rtl/tdpt_rem_unit.sv @@
// ----------------------------------------------------------------------------
// tdpt_rem_unit - bit-serial remainder unit
// Restoring shift-subtract: one dividend bit per cycle over all VALUE_BITS
// bits of the dividend. Only the remainder is kept; the quotient is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_rem_unit #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF,
    parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [DIV_BITS-1:0]   divisor,
    output tdpt_pkg::rem_sts_t         sts
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] shift_reg;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   div_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_BITS:0]     trial;

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, shift_reg[VALUE_BITS-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = DIV_BITS'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_BITS'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(VALUE_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= rem_next;
        end
    end

    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == '0);

endmodule

`default_nettype wire

@@ hw/rtl/tdpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdpt_ctrl - trial divisor sequencer
// Holds the value, steps the divisor from 2 while d*d <= value (square kept
// incrementally), runs the remainder unit per divisor and hands the verdict
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF,
    parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic                  out_free,
    input  tdpt_pkg::rem_sts_t         rem_sts,
    output logic                       rem_start,
    output logic [VALUE_BITS-1:0]      rem_dividend,
    output logic [DIV_BITS-1:0]        rem_divisor,
    output tdpt_pkg::ctrl_sts_t        sts
);

    localparam int SQ_BITS = 2 * DIV_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] held_value_reg;
    logic [DIV_BITS-1:0]   divisor_reg;
    logic [SQ_BITS-1:0]    square_reg;
    logic                  prime_reg;
    logic                  in_take;
    logic                  sq_over;

    assign in_take = in_valid && (state_reg == ST_IDLE);
    assign sq_over = square_reg > SQ_BITS'(held_value_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_value < VALUE_BITS'(2)) ? ST_FINISH : ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sq_over ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (rem_sts.done) begin
                    state_next = rem_sts.zero ? ST_FINISH : ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_value_reg <= '0;
            divisor_reg    <= '0;
            square_reg     <= '0;
            prime_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_take) begin
                held_value_reg <= in_value;
                divisor_reg    <= DIV_BITS'(tdpt_pkg::FIRST_DIVISOR);
                square_reg     <= SQ_BITS'(tdpt_pkg::FIRST_SQUARE);
                prime_reg      <= 1'b0;
            end
            if (state_reg == ST_CHECK && sq_over) begin
                prime_reg <= 1'b1;
            end
            // (d+1)^2 = d^2 + 2d + 1
            if (state_reg == ST_DIVIDE && rem_sts.done && !rem_sts.zero) begin
                divisor_reg <= divisor_reg + DIV_BITS'(1);
                square_reg  <= square_reg + SQ_BITS'({divisor_reg, 1'b1});
            end
        end
    end

    assign rem_start    = (state_reg == ST_CHECK) && !sq_over;
    assign rem_dividend = held_value_reg;
    assign rem_divisor  = divisor_reg;

    assign sts.in_ready  = (state_reg == ST_IDLE);
    assign sts.out_load  = (state_reg == ST_FINISH) && out_free;
    assign sts.out_prime = prime_reg;

endmodule

`default_nettype wire
